// File: sv/brf_pkg.sv
// shared constants, types and the notice text for the byte ring fifo
package brf_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 7;
    localparam int NOTICE_W       = 5;
    localparam int NOTICE_LEN     = 19;
    localparam int DEF_RING_DEPTH = 256;
    localparam int DEF_MAX_GET    = 64;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [NOTICE_LEN*BYTE_W-1:0] NOTICE_TEXT =
        {"ring buf is full!", 8'h0d, 8'h0a};

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_PUT,
        SEL_NOTICE,
        SEL_DATA
    } t_out_sel;

    typedef struct packed {
        logic                wr_en;
        logic                rd_adv;
        logic                load;
        t_out_sel            sel;
        logic [NOTICE_W-1:0] notice_idx;
        logic                dropped;
        logic                empty;
        logic                last;
    } t_dp_cmd;

    typedef struct packed {
        logic             full;
        logic             out_free;
        logic [LEN_W-1:0] stored_sat;
    } t_dp_stat;

    function automatic logic [BYTE_W-1:0] notice_char(input logic [NOTICE_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        ch = '0;
        if (int'(idx) < NOTICE_LEN) begin
            ch = NOTICE_TEXT[BYTE_W*(NOTICE_LEN-1-int'(idx)) +: BYTE_W];
        end
        return ch;
    endfunction

endpackage

// File: sv/brf_in_if.sv
// request channel: command, byte to store and run length limit
interface brf_in_if;
    import brf_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] put_byte;
    logic [LEN_W-1:0]  max_length;

    modport source (output valid, command, put_byte, max_length, input ready);
    modport sink   (input valid, command, put_byte, max_length, output ready);
endinterface

// File: sv/brf_out_if.sv
// result channel: one returned byte or status per transfer
interface brf_out_if;
    import brf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              put_dropped;
    logic              ring_empty;
    logic              last_of_run;

    modport source (output valid, out_byte, has_byte, put_dropped, ring_empty, last_of_run,
                    input ready);
    modport sink   (input valid, out_byte, has_byte, put_dropped, ring_empty, last_of_run,
                    output ready);
endinterface

// File: sv/byte_ring_fifo_with_overflow_notice.sv
// top level of the byte ring fifo with overflow notice
// Usage: requests come in on i_req, results leave on o_res, both valid/ready.
// A put request stores put_byte and gives one result (has_byte 0); if the ring
// already holds RING_DEPTH-1 bytes the byte is dropped, put_dropped is 1 and
// a sticky overflow flag is set. A get request returns up to max_length
// (clipped to MAX_GET) results, one byte each: while the flag is set the run
// opens with the text "ring buf is full!" CR LF, then stored bytes follow.
// A get that yields nothing gives one result with has_byte 0. last_of_run
// marks the final result of each request, ring_empty the state after it.
// Timing: a put's result is in the output register on the next cycle after it is
// accepted. A get is planned when it is accepted, then returns one byte per cycle
// while o_res does not stall; the single output register and the one read port
// of the ring memory set that rate. The next request is taken once the run has
// been handed to the output register.
// Reset: positions and the flag clear at once; the ring memory is not cleared
// and needs no sweep. When o_res stalls the result register holds and the
// run pauses; i_req.ready stays low until the output register can take data.
module byte_ring_fifo_with_overflow_notice #(
    parameter int RING_DEPTH = brf_pkg::DEF_RING_DEPTH,
    parameter int MAX_GET    = brf_pkg::DEF_MAX_GET
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brf_in_if.sink    i_req,
    brf_out_if.source o_res
);
    import brf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    brf_ctrl #(
        .MAX_GET (MAX_GET)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    brf_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_put_byte (i_req.put_byte),
        .o_stat     (stat),
        .o_res      (o_res)
    );

    // a request is only taken when the result register can take its first result
    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !(o_res.valid && !o_res.ready))
        else $error("request taken while a result is stuck");

    // a put always shows up as a single closing result on the next cycle
    a_put_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.command == CMD_PUT))
        |=> (o_res.valid && o_res.last_of_run && !o_res.has_byte))
        else $error("put result missing");

    // a dropped put never carries a byte and closes its run
    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.put_dropped) |-> (!o_res.has_byte && o_res.last_of_run))
        else $error("dropped put result malformed");

    // empty results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.has_byte) |-> (o_res.out_byte == '0))
        else $error("byte present on a result without data");

endmodule

// File: sv/brf_datapath.sv
// ring storage, read and write positions and the result register
module brf_datapath #(
    parameter int RING_DEPTH = brf_pkg::DEF_RING_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  brf_pkg::t_dp_cmd           i_cmd,
    input  logic [brf_pkg::BYTE_W-1:0] i_put_byte,
    output brf_pkg::t_dp_stat          o_stat,
    brf_out_if.source                  o_res
);
    import brf_pkg::*;

    localparam int PW  = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int SAT = (2 ** LEN_W) - 1;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [PW-1:0]     r_rd;
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     n_rd;
    logic [PW-1:0]     wr_next;
    logic [PW-1:0]     rd_next;
    logic [PW:0]       diff;

    logic              r_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_has_byte;
    logic              r_dropped;
    logic              r_empty;
    logic              r_last;

    always_comb begin
        wr_next = (r_wr == PW'(RING_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        rd_next = (r_rd == PW'(RING_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_rd    = i_cmd.rd_adv ? rd_next : r_rd;
        diff    = {1'b0, r_wr} - {1'b0, r_rd};
        if (r_wr < r_rd) begin
            diff = diff + (PW+1)'(RING_DEPTH);
        end
    end

    always_comb begin
        o_stat.full     = (wr_next == r_rd);
        o_stat.out_free = !r_valid || o_res.ready;
        if (32'(diff) > SAT) begin
            o_stat.stored_sat = LEN_W'(SAT);
        end else begin
            o_stat.stored_sat = LEN_W'(diff);
        end
    end

    // read every cycle at the upcoming read position so the head byte is ready
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_wr] <= i_put_byte;
        end
        r_rdata <= r_mem[n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_wr <= wr_next;
            end
            r_rd <= n_rd;
            if (i_cmd.load) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_cmd.sel)
                SEL_NOTICE: r_out_byte <= notice_char(i_cmd.notice_idx);
                SEL_DATA:   r_out_byte <= r_rdata;
                default:    r_out_byte <= '0;
            endcase
            r_has_byte <= (i_cmd.sel == SEL_NOTICE) || (i_cmd.sel == SEL_DATA);
            r_dropped  <= i_cmd.dropped;
            r_empty    <= i_cmd.empty;
            r_last     <= i_cmd.last;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.out_byte    = r_out_byte;
    assign o_res.has_byte    = r_has_byte;
    assign o_res.put_dropped = r_dropped;
    assign o_res.ring_empty  = r_empty;
    assign o_res.last_of_run = r_last;

endmodule

// File: sv/brf_ctrl.sv
// request sequencer: plans each get run and steps it one result per cycle while the result register is free
module brf_ctrl #(
    parameter int MAX_GET = brf_pkg::DEF_MAX_GET
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    brf_in_if.sink            i_req,
    input  brf_pkg::t_dp_stat i_stat,
    output brf_pkg::t_dp_cmd  o_cmd
);
    import brf_pkg::*;

    localparam logic [LEN_W-1:0]    MAXG   = LEN_W'(MAX_GET);
    localparam logic [LEN_W-1:0]    NLEN_L = LEN_W'(NOTICE_LEN);
    localparam logic [NOTICE_W-1:0] NLEN_N = NOTICE_W'(NOTICE_LEN);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state              r_state;
    logic                r_pend;
    logic [LEN_W-1:0]    r_left;
    logic [NOTICE_W-1:0] r_nleft;
    logic [NOTICE_W-1:0] r_idx;
    logic                r_empty;

    logic                accept;
    logic [LEN_W-1:0]    lim;
    logic [NOTICE_W-1:0] nn;
    logic [LEN_W-1:0]    slots;
    logic [LEN_W-1:0]    dn;
    logic [LEN_W-1:0]    total;
    logic                clr;
    logic                empty_after;

    assign i_req.ready = (r_state == ST_IDLE) && i_stat.out_free;
    assign accept      = i_req.valid && i_req.ready;

    // get plan: notice part first, then as many stored bytes as fit
    always_comb begin
        lim = (i_req.max_length > MAXG) ? MAXG : i_req.max_length;
        nn    = '0;
        slots = lim;
        clr   = 1'b0;
        if (r_pend) begin
            if (lim <= NLEN_L) begin
                nn    = lim[NOTICE_W-1:0];
                slots = '0;
            end else begin
                nn    = NLEN_N;
                slots = lim - NLEN_L;
                clr   = 1'b1;
            end
        end
        dn          = (slots <= i_stat.stored_sat) ? slots : i_stat.stored_sat;
        empty_after = (slots >= i_stat.stored_sat);
        total       = LEN_W'(nn) + dn;
    end

    always_comb begin
        o_cmd = '{wr_en: 1'b0, rd_adv: 1'b0, load: 1'b0, sel: SEL_NONE,
                  notice_idx: '0, dropped: 1'b0, empty: 1'b0, last: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.command == CMD_PUT) begin
                        o_cmd.wr_en   = !i_stat.full;
                        o_cmd.load    = 1'b1;
                        o_cmd.sel     = SEL_PUT;
                        o_cmd.dropped = i_stat.full;
                        o_cmd.last    = 1'b1;
                    end else if (total == '0) begin
                        o_cmd.load  = 1'b1;
                        o_cmd.sel   = SEL_NONE;
                        o_cmd.empty = empty_after;
                        o_cmd.last  = 1'b1;
                    end
                end
            end
            ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.empty = r_empty;
                    o_cmd.last  = (r_left == LEN_W'(1));
                    if (r_nleft != '0) begin
                        o_cmd.sel        = SEL_NOTICE;
                        o_cmd.notice_idx = r_idx;
                    end else begin
                        o_cmd.sel    = SEL_DATA;
                        o_cmd.rd_adv = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_nleft <= '0;
            r_idx   <= '0;
            r_empty <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_req.command == CMD_PUT) begin
                            if (i_stat.full) begin
                                r_pend <= 1'b1;
                            end
                        end else begin
                            if (clr) begin
                                r_pend <= 1'b0;
                            end
                            if (total != '0) begin
                                r_left  <= total;
                                r_nleft <= nn;
                                r_idx   <= '0;
                                r_empty <= empty_after;
                                r_state <= ST_SEND;
                            end
                        end
                    end
                end
                ST_SEND: begin
                    if (i_stat.out_free) begin
                        r_left <= r_left - 1'b1;
                        if (r_nleft != '0) begin
                            r_nleft <= r_nleft - 1'b1;
                            r_idx   <= r_idx + 1'b1;
                        end
                        if (r_left == LEN_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: verif/tb_byte_ring_fifo_with_overflow_notice.sv
// testbench for the byte ring fifo with overflow notice: predicted results, random stalls
module tb_byte_ring_fifo_with_overflow_notice;
    import brf_pkg::*;

    localparam int RING_SLOTS     = 256;
    localparam int GET_CAP        = 64;
    localparam int NOTICE_CHARS   = 19;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [NOTICE_CHARS*8-1:0] FULL_NOTICE = {"ring buf is full!", 8'h0d, 8'h0a};

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       dropped;
        logic       empty;
        logic       last;
    } t_ring_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brf_in_if  req_if ();
    brf_out_if res_if ();

    byte_ring_fifo_with_overflow_notice uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // predictor state
    logic [7:0]   ring_mem [RING_SLOTS];
    logic [7:0]   ring_rd = '0;
    logic [7:0]   ring_wr = '0;
    logic         notice_owed = 1'b0;
    t_ring_result pending_results[$];

    int error_count   = 0;
    int stall_cycles  = 0;
    int hold_off_left = 0;
    bit no_gaps       = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic ring_is_full();
        logic [7:0] nxt;
        nxt = ring_wr + 8'd1;
        return nxt == ring_rd;
    endfunction

    task automatic predict_ring_response(input logic cmd, input logic [7:0] value,
                                         input logic [6:0] len);
        t_ring_result run[$];
        t_ring_result r;
        int           limit;
        int           sent;
        logic         full;
        logic         empty;
        r = '0;
        if (cmd == CMD_PUT) begin
            full = ring_is_full();
            if (full) begin
                notice_owed = 1'b1;
            end else begin
                ring_mem[ring_wr] = value;
                ring_wr = ring_wr + 8'd1;
            end
            r.dropped = full;
            run.push_back(r);
        end else begin
            limit = (int'(len) > GET_CAP) ? GET_CAP : int'(len);
            sent = 0;
            r.has = 1'b1;
            if (notice_owed) begin
                while (sent < limit && sent < NOTICE_CHARS) begin
                    r.data = FULL_NOTICE[8*(NOTICE_CHARS-1-sent) +: 8];
                    run.push_back(r);
                    sent++;
                end
                // the flag clears only when the whole text plus one more slot fit
                if (limit > NOTICE_CHARS) notice_owed = 1'b0;
            end
            while (ring_rd != ring_wr && sent < limit) begin
                r.data = ring_mem[ring_rd];
                run.push_back(r);
                ring_rd = ring_rd + 8'd1;
                sent++;
            end
            if (sent == 0) begin
                r = '0;
                run.push_back(r);
            end
        end
        empty = (ring_rd == ring_wr);
        foreach (run[i]) begin
            run[i].empty = empty;
            run[i].last  = (i == run.size() - 1);
            pending_results.push_back(run[i]);
        end
    endtask

    // returns at the rising edge at which the request was taken
    task automatic issue_request(input logic cmd, input logic [7:0] value,
                                 input logic [6:0] len);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 34) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.put_byte   <= value;
        req_if.max_length <= len;
        do @(posedge i_clk); while (!req_if.ready);
        predict_ring_response(cmd, value, len);
    endtask

    task automatic stop_requests();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_edge_cases();
        issue_request(CMD_GET, 8'h3c, 7'd0);
        issue_request(CMD_GET, 8'hc3, 7'd127);
        issue_request(CMD_PUT, 8'h00, 7'd0);
        issue_request(CMD_PUT, 8'hff, 7'd127);
        issue_request(CMD_PUT, 8'h80, 7'd64);
        issue_request(CMD_GET, 8'hff, 7'd0);
        issue_request(CMD_GET, 8'h00, 7'd1);
        issue_request(CMD_GET, 8'h5a, 7'd127);
        issue_request(CMD_PUT, 8'h7f, 7'd1);
        issue_request(CMD_PUT, 8'h55, 7'd65);
        issue_request(CMD_GET, 8'haa, 7'd64);
        issue_request(CMD_GET, 8'h01, 7'd64);
        stop_requests();
    endtask

    task automatic test_overflow_notice();
        int n;
        n = 0;
        while (!ring_is_full()) begin
            no_gaps = (n < 120);
            issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
            n++;
        end
        no_gaps = 1'b0;
        repeat (3) issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        // notice pending: empty run, then text cut short, then text with no room left
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd0);
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd7);
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd19);
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd20);
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd0);
        issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd127);
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd65);
        stop_requests();
    endtask

    task automatic test_backpressure();
        hold_off_left = 160;
        no_gaps = 1'b1;
        repeat (10) issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        issue_request(CMD_GET, 8'($urandom_range(255)), 7'd30);
        repeat (5) issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        no_gaps = 1'b0;
        stop_requests();
        // sender pauses until the block has handed out everything
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        int   sel;
        logic [6:0] len;
        for (int i = 0; i < 130; i++) begin
            no_gaps = (i >= 40 && i < 80);
            if ($urandom_range(99) < 75) begin
                issue_request(CMD_PUT, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else begin
                sel = $urandom_range(9);
                if (sel < 6)
                    len = 7'($urandom_range(20));
                else if (sel < 9)
                    len = 7'($urandom_range(64, 21));
                else
                    len = 7'($urandom_range(127, 65));
                issue_request(CMD_GET, 8'($urandom_range(255)), len);
            end
        end
        no_gaps = 1'b0;
        stop_requests();
    endtask

    // result sink: random stalls plus the long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                res_if.ready <= 1'b0;
                hold_off_left--;
            end else if (no_gaps) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 34);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: out_byte 0x%0h", res_if.out_byte);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_byte", want.data, res_if.out_byte);
                check_field("has_byte", want.has, res_if.has_byte);
                check_field("put_dropped", want.dropped, res_if.put_dropped);
                check_field("ring_empty", want.empty, res_if.ring_empty);
                check_field("last_of_run", want.last, res_if.last_of_run);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("byte_ring_fifo_with_overflow_notice test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_PUT;
        req_if.put_byte   = '0;
        req_if.max_length = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_overflow_notice();
        test_backpressure();
        test_random_mix();

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("byte_ring_fifo_with_overflow_notice test passed");
        else
            $display("byte_ring_fifo_with_overflow_notice test failed");
        $finish;
    end

endmodule
